// ===== rtl/hcbp_pkg.sv =====
// Shared constants and types for the Huffman code bit packer.
// No dependencies; every other file in rtl/ imports this package.
`timescale 1ns / 1ps

package hcbp_pkg;

  // Default parameter values for the top level
  localparam int unsigned SYMBOL_COUNT_DEF    = 256;
  localparam int unsigned MAX_CODE_LENGTH_DEF = 32;

  // Fixed field widths of the channels
  localparam int unsigned SYM_W    = 8;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned LENGTH_W = 6;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned BYTE_SH  = 3;   // log2 of BYTE_W

  // Request command codes
  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_LOAD   = 2'd0;
  localparam cmd_t CMD_ENCODE = 2'd1;
  localparam cmd_t CMD_FLUSH  = 2'd2;

  // Control of the request held after the table read
  typedef struct packed {
    logic vld;
    cmd_t cmd;
  } stage_ctl_t;

  // One queued output byte
  typedef struct packed {
    logic              last;
    logic [BYTE_W-1:0] data;
  } out_ent_t;

endpackage

// ===== rtl/hcbp_if.sv =====
// Channel interfaces of the Huffman code bit packer: request and byte output.
// Depends on hcbp_pkg for field widths.
`timescale 1ns / 1ps

interface hcbp_in_if import hcbp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [1:0]          command;
  logic [SYM_W-1:0]    symbol;
  logic [VALUE_W-1:0]  code_value;
  logic [LENGTH_W-1:0] code_length;

  modport source (output valid, command, symbol, code_value, code_length, input ready);
  modport sink   (input valid, command, symbol, code_value, code_length, output ready);
endinterface

interface hcbp_out_if import hcbp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] packed_byte;
  logic              last_of_run;

  modport source (output valid, packed_byte, last_of_run, input ready);
  modport sink   (input valid, packed_byte, last_of_run, output ready);
endinterface

// ===== rtl/hcbp_code_table.sv =====
// Code table: per-symbol code bits and length, with registered read.
// Depends on hcbp_pkg. Lengths read as zero until the entry is loaded.
`timescale 1ns / 1ps

module hcbp_code_table import hcbp_pkg::*; #(
  parameter int unsigned SYMBOL_COUNT = SYMBOL_COUNT_DEF,
  parameter int unsigned CODE_W       = MAX_CODE_LENGTH_DEF,
  parameter int unsigned LEN_W        = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                req_acc,
  input  cmd_t                req_cmd,
  input  logic [SYM_W-1:0]    req_symbol,
  input  logic [VALUE_W-1:0]  req_value,
  input  logic [LENGTH_W-1:0] req_length,
  output stage_ctl_t          ctl_r,
  output logic [CODE_W-1:0]   bits_r,
  output logic [LEN_W-1:0]    len
);

  localparam int unsigned IDX_W = $clog2(SYMBOL_COUNT);

  logic [CODE_W-1:0]       bits_mem [SYMBOL_COUNT];
  logic [LEN_W-1:0]        len_mem  [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0] loaded_r;
  logic [LEN_W-1:0]        len_rd_r;
  logic                    use_r;

  logic             hit;
  logic [IDX_W-1:0] idx;
  logic [LEN_W-1:0] len_sat;
  logic             wr_en;

  // Address decode and length saturation
  always_comb begin
    hit     = ({1'b0, req_symbol} < (SYM_W + 1)'(SYMBOL_COUNT));
    idx     = req_symbol[IDX_W-1:0];
    len_sat = (req_length > LENGTH_W'(CODE_W)) ? LEN_W'(CODE_W) : req_length[LEN_W-1:0];
    wr_en   = req_acc && (req_cmd == CMD_LOAD) && hit;
  end

  // Table memories: one write, one registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      bits_mem[idx] <= req_value[CODE_W-1:0];
      len_mem[idx]  <= len_sat;
    end
    if (req_acc) begin
      bits_r   <= bits_mem[idx];
      len_rd_r <= len_mem[idx];
    end
  end

  // Per-entry loaded flags and request control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r <= '0;
      ctl_r    <= '0;
      use_r    <= 1'b0;
    end else begin
      if (wr_en) begin
        loaded_r[idx] <= 1'b1;
      end
      ctl_r.vld <= req_acc;
      if (req_acc) begin
        ctl_r.cmd <= req_cmd;
        use_r     <= hit && loaded_r[idx];
      end
    end
  end

  // Unloaded or out-of-range symbols contribute no bits
  assign len = use_r ? len_rd_r : '0;

endmodule

// ===== rtl/hcbp_packer.sv =====
// Bit packer: merges one code into the byte accumulator, yields finished bytes.
// Depends on hcbp_pkg. Bytes leave left aligned, earliest first.
`timescale 1ns / 1ps

module hcbp_packer import hcbp_pkg::*; #(
  parameter int unsigned CODE_W    = MAX_CODE_LENGTH_DEF,
  parameter int unsigned LEN_W     = 6,
  parameter int unsigned MAX_BYTES = 4,
  parameter int unsigned CNT_W     = 3
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  stage_ctl_t                    ctl,
  input  logic [CODE_W-1:0]             bits,
  input  logic [LEN_W-1:0]              len,
  output logic [CNT_W-1:0]              wr_cnt,
  output logic [MAX_BYTES*BYTE_W-1:0]   wr_bytes
);

  localparam int unsigned OUT_W = MAX_BYTES * BYTE_W;
  localparam int unsigned WIN_W = OUT_W + BYTE_W;
  localparam int unsigned SH_W  = $clog2(WIN_W + 1);
  localparam int unsigned TOT_W = $clog2(CODE_W + BYTE_W);

  logic [BYTE_W-1:0]  acc_r, acc_nxt;
  logic [BYTE_SH-1:0] fill_r, fill_nxt;

  logic [CODE_W:0]    one_sh;
  logic [CODE_W:0]    mask;
  logic [CODE_W-1:0]  code_m;
  logic [SH_W-1:0]    shamt;
  logic [TOT_W-1:0]   total;
  logic [CNT_W-1:0]   nbytes;
  logic [WIN_W-1:0]   win;
  logic [WIN_W-1:0]   win_sh;

  // Place the code right after the filled bits of the accumulator
  always_comb begin
    one_sh = (CODE_W + 1)'(1) << len;
    mask   = one_sh - (CODE_W + 1)'(1);
    code_m = bits & mask[CODE_W-1:0];
    shamt  = SH_W'(WIN_W) - SH_W'(fill_r) - SH_W'(len);
    total  = TOT_W'(fill_r) + TOT_W'(len);
    nbytes = CNT_W'(total >> BYTE_SH);
    win    = {acc_r, OUT_W'(0)} | (WIN_W'(code_m) << shamt);
    win_sh = win << {nbytes, {BYTE_SH{1'b0}}};
  end

  // Command decode: what is written to the queue and what stays behind
  always_comb begin
    acc_nxt  = acc_r;
    fill_nxt = fill_r;
    wr_cnt   = '0;
    wr_bytes = win[WIN_W-1 -: OUT_W];
    if (ctl.vld) begin
      case (ctl.cmd)
        CMD_ENCODE: begin
          wr_cnt   = nbytes;
          acc_nxt  = win_sh[WIN_W-1 -: BYTE_W];
          fill_nxt = total[BYTE_SH-1:0];
        end
        CMD_FLUSH: begin
          wr_bytes = OUT_W'(acc_r) << (OUT_W - BYTE_W);
          if (fill_r != '0) begin
            wr_cnt   = CNT_W'(1);
            acc_nxt  = '0;
            fill_nxt = '0;
          end
        end
        default: begin
          wr_cnt = '0;
        end
      endcase
    end
  end

  // Accumulator state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      fill_r <= '0;
    end else begin
      acc_r  <= acc_nxt;
      fill_r <= fill_nxt;
    end
  end

endmodule

// ===== rtl/hcbp_out_fifo.sv =====
// Output byte queue: takes up to MAX_BYTES bytes a cycle, gives one a cycle
// while rd_ready. Depends on hcbp_pkg. Marks the last byte of each burst.
`timescale 1ns / 1ps

module hcbp_out_fifo import hcbp_pkg::*; #(
  parameter int unsigned MAX_BYTES = 4,
  parameter int unsigned CNT_W     = 3,
  parameter int unsigned AW        = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        pend,
  input  logic [CNT_W-1:0]            wr_cnt,
  input  logic [MAX_BYTES*BYTE_W-1:0] wr_bytes,
  output logic                        room,
  output logic [AW:0]                 level,
  output logic                        rd_valid,
  input  logic                        rd_ready,
  output out_ent_t                    rd_ent
);

  localparam int unsigned DEPTH = 1 << AW;
  localparam int unsigned OUT_W = MAX_BYTES * BYTE_W;

  out_ent_t       buf_r [DEPTH];
  logic [AW-1:0]  wp_r, wp_nxt;
  logic [AW-1:0]  rp_r, rp_nxt;
  logic [AW:0]    cnt_r, cnt_nxt;
  logic           pop;
  logic [AW+1:0]  need;

  // Pointer and fill bookkeeping
  always_comb begin
    pop     = rd_valid && rd_ready;
    wp_nxt  = wp_r + AW'(wr_cnt);
    rp_nxt  = rp_r + AW'(pop);
    cnt_nxt = cnt_r + (AW + 1)'(wr_cnt) - (AW + 1)'(pop);
    // Worst case: the burst in flight plus one from a request taken now
    need    = (AW + 2)'(cnt_r) +
              (pend ? (AW + 2)'(2 * MAX_BYTES) : (AW + 2)'(MAX_BYTES));
    room    = (need <= (AW + 2)'(DEPTH));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Burst write, earliest byte at the write pointer
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_BYTES; i++) begin
      if (CNT_W'(i) < wr_cnt) begin
        buf_r[AW'(wp_r + AW'(i))].data <= wr_bytes[OUT_W-1-BYTE_W*i -: BYTE_W];
        buf_r[AW'(wp_r + AW'(i))].last <= (CNT_W'(i + 1) == wr_cnt);
      end
    end
  end

  assign rd_valid = (cnt_r != '0);
  assign rd_ent   = buf_r[rp_r];
  assign level    = cnt_r;

endmodule

// ===== rtl/huffman_code_bit_packer_unit.sv =====
// Top level of the Huffman code bit packer: code table, packer, byte queue.
// Depends on hcbp_pkg, hcbp_if, hcbp_code_table, hcbp_packer, hcbp_out_fifo.
//
//   channel  dir  handshake            payload
//   in_ch    in   valid/ready          command, symbol, code_value, code_length
//   out_ch   out  valid/ready          packed_byte, last_of_run
//
// A request is taken every cycle while the byte queue has room for a worst-case
// burst from it plus one from any request still being packed. The table read
// is registered, packing follows in the next cycle, and the packed bytes are
// written to the byte queue, from which they are offered in order.
// Output runs at one byte per cycle while out_ch is ready. Reset is
// synchronous and needs no clearing pass: per-symbol loaded flags clear at
// once. A stalled output fills the queue and then holds off new requests.
`timescale 1ns / 1ps

module huffman_code_bit_packer_unit import hcbp_pkg::*; #(
  parameter int unsigned SYMBOL_COUNT    = SYMBOL_COUNT_DEF,
  parameter int unsigned MAX_CODE_LENGTH = MAX_CODE_LENGTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  hcbp_in_if.sink      in_ch,
  hcbp_out_if.source   out_ch
);

  localparam int unsigned CODE_W    = (MAX_CODE_LENGTH < VALUE_W) ? MAX_CODE_LENGTH : VALUE_W;
  localparam int unsigned LEN_W     = $clog2(CODE_W + 1);
  localparam int unsigned MAX_BYTES = (BYTE_W - 1 + CODE_W) / BYTE_W;
  localparam int unsigned CNT_W     = $clog2(MAX_BYTES + 1);
  localparam int unsigned AW        = $clog2(4 * MAX_BYTES);

  logic                        req_acc;
  stage_ctl_t                  ctl;
  logic [CODE_W-1:0]           rd_bits;
  logic [LEN_W-1:0]            rd_len;
  logic [CNT_W-1:0]            wr_cnt;
  logic [MAX_BYTES*BYTE_W-1:0] wr_bytes;
  logic                        room;
  logic [AW:0]                 level;
  out_ent_t                    rd_ent;

  assign in_ch.ready = room;
  assign req_acc     = in_ch.valid && room;

  // Table lookup and load
  hcbp_code_table #(
    .SYMBOL_COUNT (SYMBOL_COUNT),
    .CODE_W       (CODE_W),
    .LEN_W        (LEN_W)
  ) u_table (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_acc    (req_acc),
    .req_cmd    (in_ch.command),
    .req_symbol (in_ch.symbol),
    .req_value  (in_ch.code_value),
    .req_length (in_ch.code_length),
    .ctl_r      (ctl),
    .bits_r     (rd_bits),
    .len        (rd_len)
  );

  // Bit accumulation
  hcbp_packer #(
    .CODE_W    (CODE_W),
    .LEN_W     (LEN_W),
    .MAX_BYTES (MAX_BYTES),
    .CNT_W     (CNT_W)
  ) u_packer (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .bits     (rd_bits),
    .len      (rd_len),
    .wr_cnt   (wr_cnt),
    .wr_bytes (wr_bytes)
  );

  // Output byte queue
  hcbp_out_fifo #(
    .MAX_BYTES (MAX_BYTES),
    .CNT_W     (CNT_W),
    .AW        (AW)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .pend     (ctl.vld),
    .wr_cnt   (wr_cnt),
    .wr_bytes (wr_bytes),
    .room     (room),
    .level    (level),
    .rd_valid (out_ch.valid),
    .rd_ready (out_ch.ready),
    .rd_ent   (rd_ent)
  );

  assign out_ch.packed_byte = rd_ent.data;
  assign out_ch.last_of_run = rd_ent.last;

  // Queue never overfills
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    level <= (AW + 1)'(1 << AW))
    else $error("byte queue overflow");

  // A load writes nothing to the queue
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.vld && ctl.cmd == CMD_LOAD) |-> (wr_cnt == '0))
    else $error("load produced output bytes");

  // A flush yields at most one byte
  a_flush_one: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.vld && ctl.cmd == CMD_FLUSH) |-> (wr_cnt <= CNT_W'(1)))
    else $error("flush produced more than one byte");

  // Nothing reaches the packer without a request taken the cycle before
  a_stage_src: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.vld |-> $past(req_acc))
    else $error("packer stage valid without a taken request");

endmodule
